>>> rtl/fpw_pkg.sv
// Shared types, codes and index helper for the four-level page walk unit.
package fpw_pkg;

	localparam int FIELD_ADDR_BITS = 52;
	localparam int VIRT_BITS       = 48;
	localparam int ENTRY_BITS      = 64;
	localparam int PHYS_ADDR_BITS  = 52;
	localparam int QUEUE_DEPTH     = 2;
	localparam int PAGE_OFS_BITS   = 12;

	localparam logic [1:0] LEVEL_TOP  = 2'd0;
	localparam logic [1:0] LEVEL_LEAF = 2'd3;

	localparam int BIT_PRESENT = 0;
	localparam int BIT_USER    = 2;

	typedef enum logic [0:0] {
		ITEM_TRANSLATE = 1'b0,
		ITEM_RESPONSE  = 1'b1
	} item_kind_t;

	typedef enum logic [0:0] {
		KIND_READ   = 1'b0,
		KIND_RESULT = 1'b1
	} result_kind_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NOT_PRESENT = 2'd1,
		ST_NOT_USER    = 2'd2
	} walk_status_t;

	typedef struct packed {
		logic                       mode;
		logic [VIRT_BITS-1:0]       vaddr;
		logic [FIELD_ADDR_BITS-1:0] root_table;
		logic [ENTRY_BITS-1:0]      read_data;
	} in_item_t;

	typedef struct packed {
		logic                       kind;
		logic [FIELD_ADDR_BITS-1:0] read_addr;
		logic [FIELD_ADDR_BITS-1:0] paddr;
		logic [1:0]                 status;
	} out_item_t;

	// One classified item as it sits in the queue between front and back.
	typedef struct packed {
		item_kind_t                 kind;
		logic [VIRT_BITS-1:0]       virt;
		logic [FIELD_ADDR_BITS-1:0] top_addr;
		logic [ENTRY_BITS-1:0]      entry;
	} queue_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef struct packed {
		logic       busy;
		logic [1:0] level;
	} walk_stat_t;

	// Nine index bits of the virtual address for a table level.
	function automatic logic [8:0] entry_index(input logic [VIRT_BITS-1:0] va,
	                                           input logic [1:0] lvl);
		logic [8:0] idx;
		case (lvl)
			2'd0:    idx = va[47:39];
			2'd1:    idx = va[38:30];
			2'd2:    idx = va[29:21];
			2'd3:    idx = va[20:12];
			default: idx = va[47:39];
		endcase
		return idx;
	endfunction

endpackage

>>> rtl/four_level_page_walk_unit.sv
// Top level of the four-level page walk unit: front end, queue and walk engine.
//
// Channel  Dir  Handshake                    Payload
// item     in   item_valid / item_stall      in_item_t: mode, vaddr, root_table, read_data
// result   out  result_valid / result_stall  out_item_t: kind, read_addr, paddr, status
//
// The walk engine takes one request per cycle while the result is not stalled.
// An accepted request goes into a queue slot; its output, if it emits one, is loaded into the
// result register when it leaves the queue and the output is free. Reset clears the queue
// pointers, the walk state and the result valid flag; payload registers are not reset.
// A stalled result holds the walk engine; requests keep entering until the queue is full,
// and item_stall is simply the queue full flag.
module four_level_page_walk_unit import fpw_pkg::*; #(
	parameter int PA_BITS = PHYS_ADDR_BITS,
	parameter int QDEPTH  = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_stall,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_stall,
	output out_item_t result
);

	queue_item_t front_item;
	queue_item_t head_item;
	queue_stat_t q_stat;
	walk_stat_t  w_stat;
	logic        q_pop;

	// The front end is pure logic: it tags each request as a translate or a memory
	// response and precomputes the top-level entry address, which needs no walk state.
	fpw_front #(
		.PA_BITS(PA_BITS)
	) u_front (
		.item (item),
		.qitem(front_item)
	);

	// Requests are accepted whenever the queue has room, independent of the result side.
	assign item_stall = q_stat.full;

	fpw_queue #(
		.DEPTH(QDEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (item_valid),
		.wr_item(front_item),
		.pop    (q_pop),
		.rd_item(head_item),
		.stat   (q_stat)
	);

	// The walk engine drops requests that arrive while a walk is busy and responses that
	// arrive while idle; both still leave the queue in order.
	fpw_back #(
		.PA_BITS(PA_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.qitem       (head_item),
		.q_empty     (q_stat.empty),
		.pop         (q_pop),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.stat        (w_stat)
	);

`ifndef SYNTHESIS
	a_idle_level: assert property (@(posedge clk) disable iff (!arst_n)
		!w_stat.busy |-> (w_stat.level == LEVEL_TOP))
		else $error("walk level not reset while idle");

	a_queue_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_stat.full && q_stat.empty))
		else $error("queue reports full and empty at once");

	a_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && (result.kind == KIND_READ)) |->
		((result.paddr == '0) && (result.status == ST_OK)))
		else $error("memory read carries result fields");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.status == ST_OK) || (result.status == ST_NOT_PRESENT) ||
		                  (result.status == ST_NOT_USER)))
		else $error("undefined walk status");
`endif

endmodule

>>> rtl/fpw_front.sv
// Front end: classifies incoming requests and forms the top-level entry address.
module fpw_front import fpw_pkg::*; #(
	parameter int PA_BITS = PHYS_ADDR_BITS
) (
	input  in_item_t    item,
	output queue_item_t qitem
);

	logic [PA_BITS-1:0] root_pa;
	logic [PA_BITS-1:0] top_pa;

	// The root is taken modulo the physical address space and the sum wraps there too.
	assign root_pa = item.root_table[PA_BITS-1:0];
	assign top_pa  = root_pa + PA_BITS'({entry_index(item.vaddr, LEVEL_TOP), 3'b000});

	assign qitem.kind     = item.mode ? ITEM_RESPONSE : ITEM_TRANSLATE;
	assign qitem.virt     = item.vaddr;
	assign qitem.top_addr = FIELD_ADDR_BITS'(top_pa);
	assign qitem.entry    = item.read_data;

endmodule

>>> rtl/fpw_queue.sv
// Small register queue that decouples the front end from the walk engine.
module fpw_queue import fpw_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  queue_item_t wr_item,
	input  logic        pop,
	output queue_item_t rd_item,
	output queue_stat_t stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	queue_item_t            slots_q [DEPTH];
	logic [PTR_W-1:0]       wr_ptr_q;
	logic [PTR_W-1:0]       rd_ptr_q;
	logic [CNT_W-1:0]       count_q;
	logic                   do_push;
	logic                   do_pop;

	assign stat.full  = (count_q == CNT_W'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_item    = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> rtl/fpw_back.sv
// Walk engine: holds the walk state, checks entries and registers each result.
module fpw_back import fpw_pkg::*; #(
	parameter int PA_BITS = PHYS_ADDR_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  queue_item_t qitem,
	input  logic        q_empty,
	output logic        pop,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result,
	output walk_stat_t  stat
);

	logic                             busy_q;
	logic [1:0]                       level_q;
	logic [VIRT_BITS-1:0]             virt_q;
	logic                             out_valid_q;
	out_item_t                        out_q;

	logic                             emit;
	logic                             busy_d;
	logic [1:0]                       level_d;
	logic                             load_virt;
	out_item_t                        res;
	logic [1:0]                       level_next;
	logic [PA_BITS-PAGE_OFS_BITS-1:0] frame;

	assign pop          = !q_empty && (!out_valid_q || !result_stall);
	assign level_next   = level_q + 2'd1;
	assign frame        = qitem.entry[PA_BITS-1:PAGE_OFS_BITS];
	assign result_valid = out_valid_q;
	assign result       = out_q;
	assign stat.busy    = busy_q;
	assign stat.level   = level_q;

	always_comb begin
		emit          = 1'b0;
		busy_d        = busy_q;
		level_d       = level_q;
		load_virt     = 1'b0;
		res.kind      = KIND_READ;
		res.read_addr = '0;
		res.paddr     = '0;
		res.status    = ST_OK;
		case (qitem.kind)
			ITEM_TRANSLATE: begin
				if (!busy_q) begin
					emit          = 1'b1;
					busy_d        = 1'b1;
					level_d       = LEVEL_TOP;
					load_virt     = 1'b1;
					res.read_addr = qitem.top_addr;
				end
			end
			ITEM_RESPONSE: begin
				if (busy_q) begin
					emit = 1'b1;
					if (!qitem.entry[BIT_PRESENT]) begin
						busy_d     = 1'b0;
						level_d    = LEVEL_TOP;
						res.kind   = KIND_RESULT;
						res.status = ST_NOT_PRESENT;
					end else if (level_q != LEVEL_LEAF) begin
						level_d       = level_next;
						res.read_addr = FIELD_ADDR_BITS'(
							{frame, entry_index(virt_q, level_next), 3'b000});
					end else begin
						busy_d   = 1'b0;
						level_d  = LEVEL_TOP;
						res.kind = KIND_RESULT;
						if (!qitem.entry[BIT_USER]) begin
							res.status = ST_NOT_USER;
						end else begin
							res.paddr = FIELD_ADDR_BITS'(
								{frame, virt_q[PAGE_OFS_BITS-1:0]});
						end
					end
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			level_q     <= LEVEL_TOP;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q  <= busy_d;
				level_q <= level_d;
			end
			if (pop && emit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && load_virt) begin
			virt_q <= qitem.virt;
		end
		if (pop && emit) begin
			out_q <= res;
		end
	end

endmodule
